/* design/fwps_pkg.sv */
`default_nettype none

package fwps_pkg;

  localparam int unsigned MAG_REGS     = 4;
  localparam int unsigned MAG_WIDTH    = 8;
  localparam int unsigned TIME_WIDTH   = 32;
  localparam int unsigned OUT_WIDTH    = 32;
  localparam int unsigned FACTOR_WIDTH = 24;

  // 60000 ms/min scaled by 256 for the Q8 fraction
  localparam logic [FACTOR_WIDTH-1:0] RPM_Q8_FACTOR = 24'd15360000;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_PULSE = 2'd1,
    OP_SPEED = 2'd2,
    OP_COUNT = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic accept;
    logic mul_step;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
    logic wheel_ok;
    logic mul_last;
    logic div_last;
  } status_t;

endpackage

`default_nettype wire

/* design/fwps_ctrl.sv */
`default_nettype none

module fwps_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic [1:0]       operation_i,
  input  fwps_pkg::status_t     status_i,
  output logic                  in_ready_o,
  output fwps_pkg::cmd_t        cmd_o
);

  fwps_pkg::state_e state_q, state_d;
  logic             accept;

  assign accept = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fwps_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fwps_pkg::ST_IDLE: begin
        if (accept && operation_i == fwps_pkg::OP_SPEED && status_i.wheel_ok) begin
          state_d = fwps_pkg::ST_MUL;
        end
      end
      fwps_pkg::ST_MUL: begin
        if (status_i.mul_last) begin
          state_d = fwps_pkg::ST_DIV;
        end
      end
      fwps_pkg::ST_DIV: begin
        if (status_i.div_last) begin
          state_d = fwps_pkg::ST_DONE;
        end
      end
      fwps_pkg::ST_DONE: begin
        if (!status_i.out_busy) begin
          state_d = fwps_pkg::ST_IDLE;
        end
      end
      default: state_d = fwps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    cmd_o.accept   = accept;
    unique case (state_q)
      fwps_pkg::ST_IDLE: begin
        in_ready_o = !(operation_i == fwps_pkg::OP_COUNT && status_i.out_busy);
      end
      fwps_pkg::ST_MUL:  cmd_o.mul_step = 1'b1;
      fwps_pkg::ST_DIV:  cmd_o.div_step = 1'b1;
      fwps_pkg::ST_DONE: cmd_o.finish   = !status_i.out_busy;
      default: in_ready_o = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

/* design/fwps_dp.sv */
`default_nettype none

module fwps_dp #(
  parameter int unsigned WHEEL_COUNT = 4,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [1:0]                          cfg_index_i,
  input  wire logic [fwps_pkg::MAG_WIDTH-1:0]      cfg_data_i,
  input  wire logic [1:0]                          operation_i,
  input  wire logic [1:0]                          wheel_i,
  input  wire logic                                out_ready_i,
  input  fwps_pkg::cmd_t                           cmd_i,
  output fwps_pkg::status_t                        status_o,
  output logic                                     out_valid_o,
  output logic [fwps_pkg::OUT_WIDTH-1:0]           speed_rpm_q8_o,
  output logic [fwps_pkg::OUT_WIDTH-1:0]           pulse_count_o,
  output logic                                     speed_saturated_o
);

  localparam int unsigned FW  = fwps_pkg::FACTOR_WIDTH;
  localparam int unsigned TW  = fwps_pkg::TIME_WIDTH;
  localparam int unsigned OW  = fwps_pkg::OUT_WIDTH;
  localparam int unsigned MW  = fwps_pkg::MAG_WIDTH;
  localparam int unsigned NW  = COUNT_WIDTH + FW;
  localparam int unsigned DW  = MW + TW;
  localparam int unsigned SW  = $clog2(NW);
  localparam int unsigned CXW = (COUNT_WIDTH > OW) ? COUNT_WIDTH : OW;

  logic [COUNT_WIDTH-1:0] cnt_q  [WHEEL_COUNT];
  logic [COUNT_WIDTH-1:0] cnt_d  [WHEEL_COUNT];
  logic [TW-1:0]          last_q [WHEEL_COUNT];
  logic [TW-1:0]          last_d [WHEEL_COUNT];
  logic [TW-1:0]          ms_q, ms_d;
  logic [MW-1:0]          mag_q  [fwps_pkg::MAG_REGS];

  logic [COUNT_WIDTH-1:0] cnt_sel;
  logic [TW-1:0]          last_sel;
  logic [CXW-1:0]         cnt_ext;
  logic [OW-1:0]          cnt_clip;
  logic [TW-1:0]          elapsed;
  fwps_pkg::op_e          op;
  logic                   wheel_ok;
  logic                   load_speed;
  logic                   load_count;

  logic [COUNT_WIDTH-1:0] hold_q;
  logic [OW-1:0]          pc_hold_q;
  logic [DW-1:0]          den_q;
  logic [FW-1:0]          fac_q;
  logic [NW-1:0]          prod_q;
  logic [DW-1:0]          rem_q;
  logic [OW-1:0]          quo_q;
  logic                   ovf_q;
  logic [SW-1:0]          step_q;

  logic [DW:0]            rem_ext;
  logic [DW:0]            rem_sub;
  logic                   ge;
  logic                   sat;

  logic                   out_valid_q;
  logic [OW-1:0]          speed_q;
  logic [OW-1:0]          count_q;
  logic                   sat_q;

  assign op         = fwps_pkg::op_e'(operation_i);
  assign wheel_ok   = (32'(wheel_i) < WHEEL_COUNT);
  assign load_speed = cmd_i.accept && op == fwps_pkg::OP_SPEED && wheel_ok;
  assign load_count = cmd_i.accept && op == fwps_pkg::OP_COUNT && wheel_ok;

  always_comb begin
    cnt_sel  = '0;
    last_sel = '0;
    for (int i = 0; i < WHEEL_COUNT; i++) begin
      if (32'(wheel_i) == 32'(i)) begin
        cnt_sel  = cnt_q[i];
        last_sel = last_q[i];
      end
    end
  end

  assign cnt_ext  = CXW'(cnt_sel);
  assign cnt_clip = (cnt_ext > CXW'({OW{1'b1}})) ? {OW{1'b1}} : cnt_ext[OW-1:0];
  assign elapsed  = ms_q - last_sel;

  // wheel state
  always_comb begin
    ms_d = ms_q;
    if (cmd_i.accept && op == fwps_pkg::OP_TICK) begin
      ms_d = ms_q + TW'(1);
    end
    for (int i = 0; i < WHEEL_COUNT; i++) begin
      cnt_d[i]  = cnt_q[i];
      last_d[i] = last_q[i];
      if (cmd_i.accept && 32'(wheel_i) == 32'(i)) begin
        case (op)
          fwps_pkg::OP_PULSE: begin
            if (cnt_q[i] != {COUNT_WIDTH{1'b1}}) begin
              cnt_d[i] = cnt_q[i] + COUNT_WIDTH'(1);
            end
          end
          fwps_pkg::OP_SPEED: begin
            cnt_d[i]  = '0;
            last_d[i] = ms_q;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_q <= '0;
      for (int i = 0; i < WHEEL_COUNT; i++) begin
        cnt_q[i]  <= '0;
        last_q[i] <= '0;
      end
      for (int i = 0; i < fwps_pkg::MAG_REGS; i++) begin
        mag_q[i] <= MW'(1);
      end
    end else begin
      ms_q <= ms_d;
      for (int i = 0; i < WHEEL_COUNT; i++) begin
        cnt_q[i]  <= cnt_d[i];
        last_q[i] <= last_d[i];
      end
      if (cfg_we_i) begin
        mag_q[cfg_index_i] <= cfg_data_i;
      end
    end
  end

  // shift-add multiply by the rpm factor, then restoring long division
  assign rem_ext = {rem_q, prod_q[NW-1]};
  assign ge      = (rem_ext >= {1'b0, den_q});
  assign rem_sub = rem_ext - {1'b0, den_q};

  always_ff @(posedge clk_i) begin
    if (load_speed) begin
      hold_q    <= cnt_sel;
      pc_hold_q <= cnt_clip;
      den_q     <= DW'(mag_q[wheel_i]) * DW'(elapsed);
      fac_q     <= fwps_pkg::RPM_Q8_FACTOR;
      prod_q    <= '0;
      rem_q     <= '0;
      quo_q     <= '0;
      ovf_q     <= 1'b0;
    end else if (cmd_i.mul_step) begin
      fac_q  <= {fac_q[FW-2:0], 1'b0};
      prod_q <= {prod_q[NW-2:0], 1'b0} + (fac_q[FW-1] ? NW'(hold_q) : NW'(0));
    end else if (cmd_i.div_step) begin
      prod_q <= {prod_q[NW-2:0], 1'b0};
      rem_q  <= ge ? rem_sub[DW-1:0] : rem_ext[DW-1:0];
      quo_q  <= {quo_q[OW-2:0], ge};
      ovf_q  <= ovf_q | quo_q[OW-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (load_speed || (cmd_i.mul_step && status_o.mul_last)) begin
      step_q <= '0;
    end else if (cmd_i.mul_step || cmd_i.div_step) begin
      step_q <= step_q + SW'(1);
    end
  end

  assign sat = ovf_q || (den_q == '0);

  // result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_count || cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_count) begin
      speed_q <= '0;
      count_q <= cnt_clip;
      sat_q   <= 1'b0;
    end else if (cmd_i.finish) begin
      speed_q <= sat ? {OW{1'b1}} : quo_q;
      count_q <= pc_hold_q;
      sat_q   <= sat;
    end
  end

  assign status_o.out_busy = out_valid_q && !out_ready_i;
  assign status_o.wheel_ok = wheel_ok;
  assign status_o.mul_last = (step_q == SW'(FW - 1));
  assign status_o.div_last = (step_q == SW'(NW - 1));

  assign out_valid_o       = out_valid_q;
  assign speed_rpm_q8_o    = speed_q;
  assign pulse_count_o     = count_q;
  assign speed_saturated_o = sat_q;

endmodule

`default_nettype wire

/* design/four_wheel_pulse_speed_meter_unit.sv */
// Tick and pulse words: one per cycle while no speed query is in progress, no result word.
// Count query: result registered in the cycle after acceptance.
// Speed query: a 24-step shift-add multiply, then a COUNT_WIDTH + 24 step restoring
// divider, then the output register, loaded once the previous result has been taken;
// input held off until then, and accepted again once the unit is back in idle.
// Reset (async, active low): counters, query times and clock zero, magnets one.
`default_nettype none

module four_wheel_pulse_speed_meter_unit #(
  parameter int unsigned WHEEL_COUNT = 4,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [1:0]                      cfg_index_i,
  input  wire logic [fwps_pkg::MAG_WIDTH-1:0]  cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [1:0]                      operation_i,
  input  wire logic [1:0]                      wheel_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [fwps_pkg::OUT_WIDTH-1:0]       speed_rpm_q8_o,
  output logic [fwps_pkg::OUT_WIDTH-1:0]       pulse_count_o,
  output logic                                 speed_saturated_o
);

  fwps_pkg::cmd_t    cmd;
  fwps_pkg::status_t status;

  fwps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .status_i    (status),
    .in_ready_o  (in_ready_o),
    .cmd_o       (cmd)
  );

  fwps_dp #(
    .WHEEL_COUNT (WHEEL_COUNT),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .operation_i       (operation_i),
    .wheel_i           (wheel_i),
    .out_ready_i       (out_ready_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_valid_o       (out_valid_o),
    .speed_rpm_q8_o    (speed_rpm_q8_o),
    .pulse_count_o     (pulse_count_o),
    .speed_saturated_o (speed_saturated_o)
  );

`ifndef NO_ASSERTIONS
  a_speed_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && operation_i == fwps_pkg::OP_SPEED
     && 32'(wheel_i) < WHEEL_COUNT) |=> !in_ready_o)
    else $error("speed query did not occupy the divider");

  a_count_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && operation_i == fwps_pkg::OP_COUNT
     && 32'(wheel_i) < WHEEL_COUNT)
    |=> (out_valid_o && speed_rpm_q8_o == '0 && !speed_saturated_o))
    else $error("count query word missing");

  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && speed_saturated_o) |-> (speed_rpm_q8_o == '1))
    else $error("saturated speed not all ones");
`endif

endmodule

`default_nettype wire
